@@ hdl/slic_pkg.sv @@
// Package for the segment/line intersection core.
// Holds default configuration constants shared by the interfaces and modules.
`timescale 1ns / 1ps
package slic_pkg;

   // Default coordinate format: signed Q16.16.
   localparam int COORD_WIDTH_DEF = 32;
   localparam int FRAC_BITS_DEF   = 16;

endpackage

@@ hdl/slic_if.sv @@
// Valid/ready channel interfaces for the intersection core.
// Depends on slic_pkg for the default coordinate width.
`timescale 1ns / 1ps
interface slic_req_if import slic_pkg::*; #(
   parameter int COORD_WIDTH = COORD_WIDTH_DEF
) ();
   logic                          valid;
   logic                          ready;
   logic signed [COORD_WIDTH-1:0] seg1_start_x;
   logic signed [COORD_WIDTH-1:0] seg1_start_y;
   logic signed [COORD_WIDTH-1:0] seg1_end_x;
   logic signed [COORD_WIDTH-1:0] seg1_end_y;
   logic signed [COORD_WIDTH-1:0] seg2_start_x;
   logic signed [COORD_WIDTH-1:0] seg2_start_y;
   logic signed [COORD_WIDTH-1:0] seg2_end_x;
   logic signed [COORD_WIDTH-1:0] seg2_end_y;
   logic                          test_second;

   modport source (output valid, seg1_start_x, seg1_start_y, seg1_end_x, seg1_end_y,
                   seg2_start_x, seg2_start_y, seg2_end_x, seg2_end_y, test_second,
                   input ready);
   modport sink (input valid, seg1_start_x, seg1_start_y, seg1_end_x, seg1_end_y,
                 seg2_start_x, seg2_start_y, seg2_end_x, seg2_end_y, test_second,
                 output ready);
endinterface

interface slic_rsp_if import slic_pkg::*; #(
   parameter int COORD_WIDTH = COORD_WIDTH_DEF
) ();
   logic                          valid;
   logic                          ready;
   logic signed [COORD_WIDTH-1:0] hit_x;
   logic signed [COORD_WIDTH-1:0] hit_y;
   logic                          hit_exists;
   logic                          is_parallel;

   modport source (output valid, hit_x, hit_y, hit_exists, is_parallel, input ready);
   modport sink (input valid, hit_x, hit_y, hit_exists, is_parallel, output ready);
endinterface

@@ hdl/slic_div_cell.sv @@
// One restoring-division cell: resolves a single quotient bit per transfer.
// Used in a chain by segment_line_intersection_core; depends on slic_pkg.
`timescale 1ns / 1ps
module slic_div_cell import slic_pkg::*; #(
   parameter int RW    = 100,
   parameter int NW    = 67,
   parameter int QW    = 31,
   parameter int SBW   = 136,
   parameter int SHIFT = 0
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           in_valid,
   output logic           in_ready,
   input  logic [RW-1:0]  in_rem,
   input  logic [QW-1:0]  in_quot,
   input  logic [NW-1:0]  in_div,
   input  logic [SBW-1:0] in_sb,
   output logic           out_valid,
   input  logic           out_ready,
   output logic [RW-1:0]  out_rem,
   output logic [QW-1:0]  out_quot,
   output logic [NW-1:0]  out_div,
   output logic [SBW-1:0] out_sb
);

   logic           valid_ff;
   logic [RW-1:0]  rem_ff, rem_in;
   logic [QW-1:0]  quot_ff, quot_in;
   logic [NW-1:0]  div_ff;
   logic [SBW-1:0] sb_ff;
   logic [RW:0]    trial;

   // The cell can take a transfer when empty or when its content moves on.
   assign in_ready = !valid_ff || out_ready;

   // Trial subtraction of the shifted divisor decides this quotient bit.
   always_comb begin
      trial   = {1'b0, in_rem} - {1'b0, (RW'(in_div) << SHIFT)};
      rem_in  = in_rem;
      quot_in = in_quot;
      if (!trial[RW]) begin
         rem_in         = trial[RW-1:0];
         quot_in[SHIFT] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
      if (in_ready && in_valid) begin
         rem_ff  <= rem_in;
         quot_ff <= quot_in;
         div_ff  <= in_div;
         sb_ff   <= in_sb;
      end
   end

   assign out_valid = valid_ff;
   assign out_rem   = rem_ff;
   assign out_quot  = quot_ff;
   assign out_div   = div_ff;
   assign out_sb    = sb_ff;

endmodule

@@ hdl/segment_line_intersection_core.sv @@
// Segment/line intersection core, top level.
// Depends on slic_pkg, slic_if (channel interfaces) and slic_div_cell.
//
// Usage:
//   req_chan carries two lines (four Q16.16 endpoints) and test_second.
//   rsp_chan returns one result per request: the intersection point,
//   hit_exists and is_parallel. Both use valid/ready; a transfer happens
//   on a clock edge where valid and ready are both high.
// Pipeline: a request is registered in stages A to E, then in each cell of the
//   division chain, then in stages G, H and I and at last in the output
//   register of stage J, which drives rsp_chan.
// Throughput: one request per cycle when nothing stalls. The quotient is resolved by
//   a chain of COORD_WIDTH - 1 division cells, one bit per cell, with every cell
//   working on a different request.
// Stalls: each stage holds its item while the one after it is full, and
//   empty stages keep filling, so requests are still taken while a finished
//   response waits at the output register.
// Reset: synchronous, active high; it empties the pipeline. There is no
//   configuration and no state kept between requests.
`timescale 1ns / 1ps
module segment_line_intersection_core import slic_pkg::*; #(
   parameter int COORD_WIDTH = COORD_WIDTH_DEF,
   parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
   input logic        clock,
   input logic        reset,
   slic_req_if.sink   req_chan,
   slic_rsp_if.source rsp_chan
);

   localparam int CW    = COORD_WIDTH;
   localparam int DW    = CW + 1;
   localparam int PW    = 2 * DW;
   localparam int NW    = PW + 1;
   localparam int RW    = NW + FRAC_BITS + CW;
   localparam int QW    = CW - 1;
   localparam int SBW   = 2 * CW + 2 * DW + 4;
   localparam int PRW   = CW + DW;
   localparam int SW    = PRW + 1;
   localparam int DEPTH = CW + 8;
   localparam int OCW   = $clog2(DEPTH + 1);

   localparam logic signed [CW-1:0] CoordMax = {1'b0, {(CW-1){1'b1}}};
   localparam logic signed [CW-1:0] CoordMin = {1'b1, {(CW-1){1'b0}}};

   // Stage A: coordinate differences.
   logic                 a_v_ff, a_rdy;
   logic signed [CW-1:0] a_x1_ff, a_y1_ff;
   logic signed [DW-1:0] a_dx12_ff, a_dy12_ff, a_dx34_ff, a_dy34_ff, a_dx13_ff, a_dy13_ff;
   logic                 a_sec_ff;
   // Stage B: cross products.
   logic                 b_v_ff, b_rdy;
   logic signed [CW-1:0] b_x1_ff, b_y1_ff;
   logic signed [DW-1:0] b_dx12_ff, b_dy12_ff;
   logic signed [PW-1:0] b_d1_ff, b_d2_ff, b_t1_ff, b_t2_ff, b_u1_ff, b_u2_ff;
   logic                 b_sec_ff;
   // Stage C: determinant and numerators.
   logic                 c_v_ff, c_rdy;
   logic signed [CW-1:0] c_x1_ff, c_y1_ff;
   logic signed [DW-1:0] c_dx12_ff, c_dy12_ff;
   logic signed [NW-1:0] c_den_ff, c_tn_ff, c_un_ff;
   logic                 c_sec_ff;
   // Stage D: signs and magnitudes.
   logic                 d_v_ff, d_rdy;
   logic signed [CW-1:0] d_x1_ff, d_y1_ff;
   logic signed [DW-1:0] d_dx12_ff, d_dy12_ff;
   logic [NW-1:0]        d_mden_ff, d_mtn_ff, d_msel_ff;
   logic [NW-1:0]        d_mden_in, d_mtn_in, d_msel_in;
   logic signed [NW-1:0] d_sel;
   logic                 d_dneg_ff, d_tneg_ff, d_sneg_ff, d_szero_ff, d_dzero_ff;
   // Stage E: range test, saturation check and division setup.
   logic                 e_v_ff, e_rdy;
   logic [RW-1:0]        e_rem_ff;
   logic [NW-1:0]        e_div_ff;
   logic [SBW-1:0]       e_sb_ff;
   logic                 e_exists_in, e_sat_in;
   // Division chain.
   logic                 cv   [0:QW];
   logic                 crdy [0:QW];
   logic [RW-1:0]        crem [0:QW];
   logic [QW-1:0]        cquot[0:QW];
   logic [NW-1:0]        cdiv [0:QW];
   logic [SBW-1:0]       csb  [0:QW];
   // Stage G: signed, saturated ratio t.
   logic                 g_v_ff, g_rdy;
   logic signed [CW-1:0] g_t_ff, g_t_in, g_q;
   logic signed [CW-1:0] g_x1_ff, g_y1_ff, s_x1, s_y1;
   logic signed [DW-1:0] g_ddx_ff, g_ddy_ff, s_dx12, s_dy12;
   logic                 g_ex_ff, g_par_ff, s_neg, s_sat, s_ex, s_par;
   // Stage H: offset products.
   logic                  h_v_ff, h_rdy;
   logic signed [CW-1:0]  h_x1_ff, h_y1_ff;
   logic signed [PRW-1:0] h_px_ff, h_py_ff;
   logic                  h_ex_ff, h_par_ff;
   // Stage I: truncated magnitudes of the offsets.
   logic                  i_v_ff, i_rdy;
   logic signed [CW-1:0]  i_x1_ff, i_y1_ff;
   logic [PRW-1:0]        i_mx_ff, i_my_ff;
   logic                  i_nx_ff, i_ny_ff, i_ex_ff, i_par_ff;
   // Stage J: output register.
   logic                  j_v_ff, j_rdy;
   logic signed [CW-1:0]  j_hx_ff, j_hy_ff, j_hx_in, j_hy_in;
   logic signed [SW-1:0]  j_sx, j_sy;
   logic                  j_ex_ff, j_par_ff;
   // Items in flight, for checking.
   logic [OCW-1:0]        occ_ff;

   // Ready chain: a stage takes a transfer when empty or when it drains.
   assign a_rdy = !a_v_ff || b_rdy;
   assign b_rdy = !b_v_ff || c_rdy;
   assign c_rdy = !c_v_ff || d_rdy;
   assign d_rdy = !d_v_ff || e_rdy;
   assign e_rdy = !e_v_ff || crdy[0];
   assign g_rdy = !g_v_ff || h_rdy;
   assign h_rdy = !h_v_ff || i_rdy;
   assign i_rdy = !i_v_ff || j_rdy;
   assign j_rdy = !j_v_ff || rsp_chan.ready;
   assign req_chan.ready = a_rdy;

   // Stage A: differences of the endpoints, exact in CW+1 bits.
   always_ff @(posedge clock) begin
      if (reset) begin
         a_v_ff <= 1'b0;
      end else if (a_rdy) begin
         a_v_ff <= req_chan.valid;
      end
      if (a_rdy && req_chan.valid) begin
         a_x1_ff   <= req_chan.seg1_start_x;
         a_y1_ff   <= req_chan.seg1_start_y;
         a_dx12_ff <= DW'(req_chan.seg1_start_x) - DW'(req_chan.seg1_end_x);
         a_dy12_ff <= DW'(req_chan.seg1_start_y) - DW'(req_chan.seg1_end_y);
         a_dx34_ff <= DW'(req_chan.seg2_start_x) - DW'(req_chan.seg2_end_x);
         a_dy34_ff <= DW'(req_chan.seg2_start_y) - DW'(req_chan.seg2_end_y);
         a_dx13_ff <= DW'(req_chan.seg1_start_x) - DW'(req_chan.seg2_start_x);
         a_dy13_ff <= DW'(req_chan.seg1_start_y) - DW'(req_chan.seg2_start_y);
         a_sec_ff  <= req_chan.test_second;
      end
   end

   // Stage B: the six cross products, one multiplier each.
   always_ff @(posedge clock) begin
      if (reset) begin
         b_v_ff <= 1'b0;
      end else if (b_rdy) begin
         b_v_ff <= a_v_ff;
      end
      if (b_rdy && a_v_ff) begin
         b_x1_ff   <= a_x1_ff;
         b_y1_ff   <= a_y1_ff;
         b_dx12_ff <= a_dx12_ff;
         b_dy12_ff <= a_dy12_ff;
         b_d1_ff   <= a_dx12_ff * a_dy34_ff;
         b_d2_ff   <= a_dy12_ff * a_dx34_ff;
         b_t1_ff   <= a_dx13_ff * a_dy34_ff;
         b_t2_ff   <= a_dy13_ff * a_dx34_ff;
         b_u1_ff   <= a_dx13_ff * a_dy12_ff;
         b_u2_ff   <= a_dy13_ff * a_dx12_ff;
         b_sec_ff  <= a_sec_ff;
      end
   end

   // Stage C: determinant and the numerators of t and u.
   always_ff @(posedge clock) begin
      if (reset) begin
         c_v_ff <= 1'b0;
      end else if (c_rdy) begin
         c_v_ff <= b_v_ff;
      end
      if (c_rdy && b_v_ff) begin
         c_x1_ff   <= b_x1_ff;
         c_y1_ff   <= b_y1_ff;
         c_dx12_ff <= b_dx12_ff;
         c_dy12_ff <= b_dy12_ff;
         c_den_ff  <= NW'(b_d1_ff) - NW'(b_d2_ff);
         c_tn_ff   <= NW'(b_t1_ff) - NW'(b_t2_ff);
         c_un_ff   <= NW'(b_u1_ff) - NW'(b_u2_ff);
         c_sec_ff  <= b_sec_ff;
      end
   end

   // Stage D: magnitudes; the most negative value maps to its unsigned size.
   always_comb begin
      d_sel     = c_sec_ff ? c_un_ff : c_tn_ff;
      d_mden_in = c_den_ff[NW-1] ? NW'(~c_den_ff + 1'b1) : NW'(c_den_ff);
      d_mtn_in  = c_tn_ff[NW-1] ? NW'(~c_tn_ff + 1'b1) : NW'(c_tn_ff);
      d_msel_in = d_sel[NW-1] ? NW'(~d_sel + 1'b1) : NW'(d_sel);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         d_v_ff <= 1'b0;
      end else if (d_rdy) begin
         d_v_ff <= c_v_ff;
      end
      if (d_rdy && c_v_ff) begin
         d_x1_ff    <= c_x1_ff;
         d_y1_ff    <= c_y1_ff;
         d_dx12_ff  <= c_dx12_ff;
         d_dy12_ff  <= c_dy12_ff;
         d_mden_ff  <= d_mden_in;
         d_mtn_ff   <= d_mtn_in;
         d_msel_ff  <= d_msel_in;
         d_dneg_ff  <= c_den_ff[NW-1];
         d_tneg_ff  <= c_tn_ff[NW-1];
         d_sneg_ff  <= d_sel[NW-1];
         d_szero_ff <= (d_sel == '0);
         d_dzero_ff <= (c_den_ff == '0);
      end
   end

   // Stage E: exact range test of the chosen ratio, and a check whether the
   // quotient reaches the saturation bound before the division starts.
   always_comb begin
      e_exists_in = !d_dzero_ff && (d_szero_ff ||
                    ((d_sneg_ff == d_dneg_ff) && (d_msel_ff <= d_mden_ff)));
      e_sat_in    = ((RW'(d_mtn_ff) << FRAC_BITS) >= (RW'(d_mden_ff) << (CW - 1)));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         e_v_ff <= 1'b0;
      end else if (e_rdy) begin
         e_v_ff <= d_v_ff;
      end
      if (e_rdy && d_v_ff) begin
         e_rem_ff <= RW'(d_mtn_ff) << FRAC_BITS;
         e_div_ff <= d_mden_ff;
         e_sb_ff  <= {d_x1_ff, d_y1_ff, d_dx12_ff, d_dy12_ff,
                      d_tneg_ff ^ d_dneg_ff, e_sat_in, e_exists_in, d_dzero_ff};
      end
   end

   // Division chain: cell k resolves quotient bit QW-1-k.
   assign cv[0]    = e_v_ff;
   assign crem[0]  = e_rem_ff;
   assign cquot[0] = '0;
   assign cdiv[0]  = e_div_ff;
   assign csb[0]   = e_sb_ff;
   assign crdy[QW] = g_rdy;

   for (genvar k = 0; k < QW; k++) begin : g_cell
      slic_div_cell #(
         .RW(RW), .NW(NW), .QW(QW), .SBW(SBW), .SHIFT(QW - 1 - k)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .in_valid (cv[k]),
         .in_ready (crdy[k]),
         .in_rem   (crem[k]),
         .in_quot  (cquot[k]),
         .in_div   (cdiv[k]),
         .in_sb    (csb[k]),
         .out_valid(cv[k+1]),
         .out_ready(crdy[k+1]),
         .out_rem  (crem[k+1]),
         .out_quot (cquot[k+1]),
         .out_div  (cdiv[k+1]),
         .out_sb   (csb[k+1])
      );
   end

   // Stage G: apply the sign and the saturation bound to the quotient.
   assign {s_x1, s_y1, s_dx12, s_dy12, s_neg, s_sat, s_ex, s_par} = csb[QW];

   always_comb begin
      g_q = $signed({1'b0, cquot[QW]});
      if (s_sat) begin
         g_t_in = s_neg ? CoordMin : CoordMax;
      end else begin
         g_t_in = s_neg ? -g_q : g_q;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         g_v_ff <= 1'b0;
      end else if (g_rdy) begin
         g_v_ff <= cv[QW];
      end
      if (g_rdy && cv[QW]) begin
         g_t_ff   <= g_t_in;
         g_x1_ff  <= s_x1;
         g_y1_ff  <= s_y1;
         g_ddx_ff <= -s_dx12;
         g_ddy_ff <= -s_dy12;
         g_ex_ff  <= s_ex;
         g_par_ff <= s_par;
      end
   end

   // Stage H: t times the direction of the first line.
   always_ff @(posedge clock) begin
      if (reset) begin
         h_v_ff <= 1'b0;
      end else if (h_rdy) begin
         h_v_ff <= g_v_ff;
      end
      if (h_rdy && g_v_ff) begin
         h_px_ff  <= g_t_ff * g_ddx_ff;
         h_py_ff  <= g_t_ff * g_ddy_ff;
         h_x1_ff  <= g_x1_ff;
         h_y1_ff  <= g_y1_ff;
         h_ex_ff  <= g_ex_ff;
         h_par_ff <= g_par_ff;
      end
   end

   // Stage I: drop the fraction bits, truncating toward zero.
   always_ff @(posedge clock) begin
      if (reset) begin
         i_v_ff <= 1'b0;
      end else if (i_rdy) begin
         i_v_ff <= h_v_ff;
      end
      if (i_rdy && h_v_ff) begin
         i_mx_ff  <= (h_px_ff[PRW-1] ? PRW'(~h_px_ff + 1'b1) : PRW'(h_px_ff)) >> FRAC_BITS;
         i_my_ff  <= (h_py_ff[PRW-1] ? PRW'(~h_py_ff + 1'b1) : PRW'(h_py_ff)) >> FRAC_BITS;
         i_nx_ff  <= h_px_ff[PRW-1];
         i_ny_ff  <= h_py_ff[PRW-1];
         i_x1_ff  <= h_x1_ff;
         i_y1_ff  <= h_y1_ff;
         i_ex_ff  <= h_ex_ff;
         i_par_ff <= h_par_ff;
      end
   end

   // Stage J: add the start point, saturate, and hold the response.
   always_comb begin
      j_sx = i_nx_ff ? SW'(i_x1_ff) - $signed({1'b0, i_mx_ff})
                     : SW'(i_x1_ff) + $signed({1'b0, i_mx_ff});
      j_sy = i_ny_ff ? SW'(i_y1_ff) - $signed({1'b0, i_my_ff})
                     : SW'(i_y1_ff) + $signed({1'b0, i_my_ff});
      if (j_sx > SW'(CoordMax)) begin
         j_hx_in = CoordMax;
      end else if (j_sx < SW'(CoordMin)) begin
         j_hx_in = CoordMin;
      end else begin
         j_hx_in = j_sx[CW-1:0];
      end
      if (j_sy > SW'(CoordMax)) begin
         j_hy_in = CoordMax;
      end else if (j_sy < SW'(CoordMin)) begin
         j_hy_in = CoordMin;
      end else begin
         j_hy_in = j_sy[CW-1:0];
      end
      if (i_par_ff) begin
         j_hx_in = '0;
         j_hy_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         j_v_ff <= 1'b0;
      end else if (j_rdy) begin
         j_v_ff <= i_v_ff;
      end
      if (j_rdy && i_v_ff) begin
         j_hx_ff  <= j_hx_in;
         j_hy_ff  <= j_hy_in;
         j_ex_ff  <= i_ex_ff;
         j_par_ff <= i_par_ff;
      end
   end

   assign rsp_chan.valid       = j_v_ff;
   assign rsp_chan.hit_x       = j_hx_ff;
   assign rsp_chan.hit_y       = j_hy_ff;
   assign rsp_chan.hit_exists  = j_ex_ff;
   assign rsp_chan.is_parallel = j_par_ff;

   // Count of requests taken whose responses are not yet delivered.
   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff <= '0;
      end else begin
         occ_ff <= occ_ff + OCW'(req_chan.valid && req_chan.ready)
                          - OCW'(rsp_chan.valid && rsp_chan.ready);
      end
   end

   // The pipeline never holds more items than it has stages.
   assert property (@(posedge clock) disable iff (reset) occ_ff <= OCW'(DEPTH))
      else $error("more items in flight than pipeline stages");

   // A response can only be offered when some request is outstanding.
   assert property (@(posedge clock) disable iff (reset) rsp_chan.valid |-> occ_ff != '0)
      else $error("response without an outstanding request");

   // Parallel lines report no hit and a zero point.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.is_parallel) |->
      (!rsp_chan.hit_exists && rsp_chan.hit_x == '0 && rsp_chan.hit_y == '0))
      else $error("parallel result carries a hit");

endmodule

@@ tb/tb.sv @@
// Testbench for the segment/line intersection core.
// Depends on slic_pkg, slic_if and segment_line_intersection_core; self-checking
// against an exact wide-integer predictor with random sender gaps and receiver stalls.
`timescale 1ns / 1ps
module tb;
   import slic_pkg::*;

   localparam int CW = COORD_WIDTH_DEF;
   localparam int FB = FRAC_BITS_DEF;
   localparam int N_RANDOM = 1250;
   localparam longint CYCLE_LIMIT = 400000;

   typedef logic signed [CW-1:0] coord_type;

   typedef struct packed {
      coord_type x1, y1, x2, y2, x3, y3, x4, y4;
      logic      second;
   } lines_type;

   typedef struct packed {
      coord_type hx, hy;
      logic      exists;
      logic      parallel;
   } hit_type;

   typedef struct {
      lines_type ln;
      logic      fixed;   // expected value typed into the table
      hit_type   want;
   } row_type;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   longint  cycle_count = 0;
   int      fail_count = 0;
   bit      stim_done = 1'b0;
   hit_type hit_queue[$];

   slic_req_if #(.COORD_WIDTH(CW)) req_chan ();
   slic_rsp_if #(.COORD_WIDTH(CW)) rsp_chan ();

   segment_line_intersection_core #(.COORD_WIDTH(CW), .FRAC_BITS(FB)) u_dut (
      .clock   (clock),
      .reset   (reset),
      .req_chan(req_chan.sink),
      .rsp_chan(rsp_chan.source)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Saturate a wide signed value to the coordinate range.
   function automatic logic signed [127:0] clamp_coord(logic signed [127:0] v);
      logic signed [127:0] hi_lim;
      logic signed [127:0] lo_lim;
      hi_lim = (128'sd1 <<< (CW - 1)) - 1;
      lo_lim = -(128'sd1 <<< (CW - 1));
      if (v > hi_lim) return hi_lim;
      if (v < lo_lim) return lo_lim;
      return v;
   endfunction

   // Point on the first line at ratio t; the offset truncates toward zero.
   function automatic coord_type point_at(coord_type p1, coord_type p2,
                                          logic signed [127:0] t);
      logic signed [127:0] prod;
      logic signed [127:0] off;
      logic signed [127:0] d;
      d = 128'(p2) - 128'(p1);
      prod = t * d;
      off = (prod < 0) ? -((-prod) >>> FB) : (prod >>> FB);
      return coord_type'(clamp_coord(128'(p1) + off));
   endfunction

   // Ratio num/den lies in [0,1], tested by sign and magnitude.
   function automatic logic ratio_in_unit(logic signed [127:0] num, logic signed [127:0] den);
      logic signed [127:0] an;
      logic signed [127:0] ad;
      if (num == 0) return 1'b1;
      if ((num < 0) != (den < 0)) return 1'b0;
      an = (num < 0) ? -num : num;
      ad = (den < 0) ? -den : den;
      return an <= ad;
   endfunction

   function automatic hit_type predict_hit(lines_type l);
      logic signed [127:0] dx12, dy12, dx34, dy34, dx13, dy13;
      logic signed [127:0] den, tn, un, q, t;
      hit_type r;
      dx12 = 128'(l.x1) - 128'(l.x2);
      dy12 = 128'(l.y1) - 128'(l.y2);
      dx34 = 128'(l.x3) - 128'(l.x4);
      dy34 = 128'(l.y3) - 128'(l.y4);
      dx13 = 128'(l.x1) - 128'(l.x3);
      dy13 = 128'(l.y1) - 128'(l.y3);
      den = dx12 * dy34 - dy12 * dx34;
      tn = dx13 * dy34 - dy13 * dx34;
      un = dx13 * dy12 - dy13 * dx12;
      if (den == 0) begin
         r.hx = '0;
         r.hy = '0;
         r.exists = 1'b0;
         r.parallel = 1'b1;
         return r;
      end
      q = (((tn < 0) ? -tn : tn) <<< FB) / ((den < 0) ? -den : den);
      t = clamp_coord(((tn < 0) != (den < 0)) ? -q : q);
      r.hx = point_at(l.x1, l.x2, t);
      r.hy = point_at(l.y1, l.y2, t);
      r.exists = ratio_in_unit(l.second ? un : tn, den);
      r.parallel = 1'b0;
      return r;
   endfunction

   function automatic coord_type rand_coord();
      case ($urandom_range(0, 9))
         0: return coord_type'({$urandom, $urandom});
         1: return $urandom_range(0, 1) ? {1'b0, {(CW-1){1'b1}}} : {1'b1, {(CW-1){1'b0}}};
         2, 3: return coord_type'($signed($urandom_range(0, 64)) - 32) <<< FB;
         default: return coord_type'($signed($urandom_range(0, 32'h0100_0000)) - 32'sh0080_0000);
      endcase
   endfunction

   function automatic lines_type rand_lines();
      lines_type l;
      l.x1 = rand_coord(); l.y1 = rand_coord();
      l.x2 = rand_coord(); l.y2 = rand_coord();
      l.x3 = rand_coord(); l.y3 = rand_coord();
      l.x4 = rand_coord(); l.y4 = rand_coord();
      l.second = 1'($urandom_range(0, 1));
      case ($urandom_range(0, 9))
         // Parallel: second line is a shifted copy of the first.
         0: begin
            l.x3 = l.x1 + 32'sh0001_0000; l.y3 = l.y1;
            l.x4 = l.x2 + 32'sh0001_0000; l.y4 = l.y2;
         end
         // Degenerate first line.
         1: begin
            l.x2 = l.x1; l.y2 = l.y1;
         end
         // Shared endpoint, ratio exactly zero or one.
         2: begin
            l.x3 = $urandom_range(0, 1) ? l.x1 : l.x2;
            l.y3 = (l.x3 == l.x1) ? l.y1 : l.y2;
         end
         default: ;
      endcase
      return l;
   endfunction

   function automatic lines_type mk(int x1, int y1, int x2, int y2, int x3, int y3,
                                    int x4, int y4, bit s);
      lines_type l;
      l = '{coord_type'(x1), coord_type'(y1), coord_type'(x2), coord_type'(y2),
            coord_type'(x3), coord_type'(y3), coord_type'(x4), coord_type'(y4), s};
      return l;
   endfunction

   row_type stim_table[$];

   initial begin
      localparam int ONE = 32'h0001_0000;
      localparam int MX = 32'h7fff_ffff;
      localparam int MN = 32'h8000_0000;
      hit_type par;
      par = '{'0, '0, 1'b0, 1'b1};
      // Parallel, coincident and degenerate lines.
      stim_table.push_back('{mk(0, 0, ONE, 0, 0, ONE, ONE, ONE, 0), 1'b1, par});
      stim_table.push_back('{mk(0, 0, ONE, ONE, 0, 0, ONE, ONE, 1), 1'b1, par});
      stim_table.push_back('{mk(0, 0, 0, 0, 0, 0, ONE, ONE, 0), 1'b1, par});
      stim_table.push_back('{mk(0, 0, 0, 0, 0, 0, 0, 0, 1), 1'b1, par});
      stim_table.push_back('{mk(MX, MX, MX, MX, MN, MN, 0, 0, 0), 1'b1, par});
      // Plain crossing at (1,1), hit within both segments.
      stim_table.push_back('{mk(0, 0, 2*ONE, 2*ONE, 0, 2*ONE, 2*ONE, 0, 0), 1'b1,
                             '{ONE, ONE, 1'b1, 1'b0}});
      stim_table.push_back('{mk(0, 0, 2*ONE, 2*ONE, 0, 2*ONE, 2*ONE, 0, 1), 1'b1,
                             '{ONE, ONE, 1'b1, 1'b0}});
      // Endpoints touching: ratio zero and ratio one.
      stim_table.push_back('{mk(0, 0, ONE, 0, 0, 0, 0, ONE, 0), 1'b1, '{0, 0, 1'b1, 1'b0}});
      stim_table.push_back('{mk(0, 0, ONE, 0, ONE, 0, ONE, ONE, 0), 1'b1,
                             '{ONE, 0, 1'b1, 1'b0}});
      // Hit beyond the first segment but within the second, checked against each, then a hit beyond both.
      stim_table.push_back('{mk(0, 0, ONE, 0, 3*ONE, -ONE, 3*ONE, ONE, 0), 1'b1,
                             '{3*ONE, 0, 1'b0, 1'b0}});
      stim_table.push_back('{mk(0, 0, ONE, 0, 3*ONE, -ONE, 3*ONE, ONE, 1), 1'b1,
                             '{3*ONE, 0, 1'b1, 1'b0}});
      stim_table.push_back('{mk(0, 0, ONE, 0, -ONE, ONE, -ONE, 2*ONE, 0), 1'b0, par});
      // Extremes: saturation of t and of the point.
      stim_table.push_back('{mk(0, 0, 1, 0, MX, -ONE, MX, ONE, 0), 1'b0, par});
      stim_table.push_back('{mk(MN, MN, MX, MX, MN, MX, MX, MN, 0), 1'b0, par});
      stim_table.push_back('{mk(MX, MN, MN, MX, MX, MX, MN, MN, 1), 1'b0, par});
      stim_table.push_back('{mk(MN, 0, MN + 1, 1, 0, MN, 1, MX, 1), 1'b0, par});
      stim_table.push_back('{mk(-1, -1, -1, -1, -1, -1, -1, -1, 1), 1'b1, par});
      stim_table.push_back('{mk(MX, MN, -1, 1, MN, MX, 0, 1, 0), 1'b0, par});
   end

   // Sender: table rows, then random items, in bursts with gaps.
   initial begin
      int burst;
      int gap;
      lines_type l;
      req_chan.valid = 1'b0;
      req_chan.test_second = 1'b0;
      {req_chan.seg1_start_x, req_chan.seg1_start_y, req_chan.seg1_end_x,
       req_chan.seg1_end_y, req_chan.seg2_start_x, req_chan.seg2_start_y,
       req_chan.seg2_end_x, req_chan.seg2_end_y} = '0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      burst = 0;
      for (int i = 0; i < stim_table.size() + N_RANDOM; i++) begin
         if (i < stim_table.size()) l = stim_table[i].ln;
         else l = rand_lines();
         if (burst == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 12) : 0;
            if (gap > 0) begin
               req_chan.valid <= 1'b0;
               repeat (gap) @(negedge clock);
            end
            burst = $urandom_range(1, 40);
         end
         burst--;
         req_chan.valid <= 1'b1;
         req_chan.seg1_start_x <= l.x1; req_chan.seg1_start_y <= l.y1;
         req_chan.seg1_end_x <= l.x2;   req_chan.seg1_end_y <= l.y2;
         req_chan.seg2_start_x <= l.x3; req_chan.seg2_start_y <= l.y3;
         req_chan.seg2_end_x <= l.x4;   req_chan.seg2_end_y <= l.y4;
         req_chan.test_second <= l.second;
         do @(posedge clock); while (!req_chan.ready);
         if (i < stim_table.size() && stim_table[i].fixed) begin
            hit_queue.push_back(stim_table[i].want);
            if (stim_table[i].want !== predict_hit(l)) begin
               $error("table row %0d disagrees with predictor", i);
               fail_count++;
            end
         end else begin
            hit_queue.push_back(predict_hit(l));
         end
         @(negedge clock);
      end
      req_chan.valid <= 1'b0;
      stim_done = 1'b1;
   end

   // Receiver stalls on a pattern that changes phase every so often.
   int stall_mode = 0;
   initial rsp_chan.ready = 1'b0;
   always @(negedge clock) begin
      if (cycle_count % 300 == 0) stall_mode <= $urandom_range(0, 3);
      case (stall_mode)
         0: rsp_chan.ready <= 1'b1;
         1: rsp_chan.ready <= ($urandom_range(0, 3) != 0);
         2: rsp_chan.ready <= (cycle_count % 7 < 2);
         default: rsp_chan.ready <= ($urandom_range(0, 1) == 1);
      endcase
   end

   // Compare each response transfer with the oldest expectation.
   always @(posedge clock) begin
      hit_type want;
      cycle_count <= cycle_count + 1;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (hit_queue.size() == 0) begin
            $error("response with no request pending");
            fail_count++;
         end else begin
            want = hit_queue.pop_front();
            if (rsp_chan.hit_x !== want.hx) begin
               $error("hit_x expected %h actual %h", want.hx, rsp_chan.hit_x);
               fail_count++;
            end
            if (rsp_chan.hit_y !== want.hy) begin
               $error("hit_y expected %h actual %h", want.hy, rsp_chan.hit_y);
               fail_count++;
            end
            if (rsp_chan.hit_exists !== want.exists) begin
               $error("hit_exists expected %b actual %b", want.exists, rsp_chan.hit_exists);
               fail_count++;
            end
            if (rsp_chan.is_parallel !== want.parallel) begin
               $error("is_parallel expected %b actual %b", want.parallel,
                      rsp_chan.is_parallel);
               fail_count++;
            end
         end
      end
   end

   // End of run: drain, wait out the latency, then report.
   initial begin
      wait (stim_done && hit_queue.size() == 0);
      repeat (3 * (CW + 8)) @(posedge clock);
      if (fail_count == 0 && hit_queue.size() == 0) $display("segment_line_intersection_core test passed");
      else $display("segment_line_intersection_core test failed");
      $finish;
   end

   // Timeout watchdog.
   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("segment_line_intersection_core test failed");
      $finish;
   end
endmodule

@@ files.f @@
hdl/slic_pkg.sv
hdl/slic_if.sv
hdl/slic_div_cell.sv
hdl/segment_line_intersection_core.sv
tb/tb.sv
